/* rtl/core/hbrp_pkg.sv */
// ----------------------------------------------------------------------------
// hbrp_pkg
// Shared widths, status codes, character codes and the parser hand-off word
// of the HTTP byte-range parser.
// ----------------------------------------------------------------------------
package hbrp_pkg;

	localparam int VALUE_W    = 63;
	localparam int DATA_W     = 63;
	localparam int PREFIX_LEN = 6;

	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_UNSAT   = 2'd2
	} status_t;

	typedef struct packed {
		logic               bad;
		logic               suffix;
		logic               digits;
		logic               last_present;
		logic [VALUE_W-1:0] first;
		logic [VALUE_W-1:0] last;
	} snap_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = 8'h62;
			3'd1:    c = 8'h79;
			3'd2:    c = 8'h74;
			3'd3:    c = 8'h65;
			3'd4:    c = 8'h73;
			3'd5:    c = 8'h3d;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/hbrp_in_if.sv */
// ----------------------------------------------------------------------------
// hbrp_in_if
// Header byte channel: one character per word plus the end-of-header mark.
// ----------------------------------------------------------------------------
interface hbrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       end_of_header;

	modport source (output valid, output header_byte, output end_of_header, input ready);
	modport sink   (input valid, input header_byte, input end_of_header, output ready);
endinterface

/* rtl/core/hbrp_res_if.sv */
// ----------------------------------------------------------------------------
// hbrp_res_if
// Result channel: status, range start and range length per word.
// ----------------------------------------------------------------------------
interface hbrp_res_if import hbrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [DATA_W-1:0] range_start;
	logic [DATA_W-1:0] range_length;

	modport source (output valid, output status, output range_start, output range_length,
		input ready);
	modport sink   (input valid, input status, input range_start, input range_length,
		output ready);
endinterface

/* rtl/core/hbrp_cfg_if.sv */
// ----------------------------------------------------------------------------
// hbrp_cfg_if
// Configuration write channel carrying the resource size.
// ----------------------------------------------------------------------------
interface hbrp_cfg_if import hbrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] resource_size;

	modport source (output valid, output resource_size, input ready);
	modport sink   (input valid, input resource_size, output ready);
endinterface

/* rtl/core/http_byte_range_parser.sv */
// ----------------------------------------------------------------------------
// http_byte_range_parser
// Parses an HTTP Range header of the form "bytes=first-last", "bytes=first-"
// or "bytes=-N" and checks the range against the configured resource size.
// ----------------------------------------------------------------------------
// The block takes one header byte per clock with no gaps needed between
// headers, unless an end-of-header byte waits on the snapshot register; the
// per-byte decimal accumulate (times ten plus digit, with overflow check) in
// the parser stage sets that figure. Results pass the snapshot and check
// registers and wait in the output register until taken while bytes flow on.
// resource_size is written through the configuration channel, which is always
// ready, and must only change while no header is in flight.
module http_byte_range_parser import hbrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hbrp_in_if.sink    in_ch,
	hbrp_res_if.source res_ch,
	hbrp_cfg_if.sink   cfg_ch
);

	logic [DATA_W-1:0] size_q;
	logic [DATA_W-1:0] size_m1_q;
	logic              snap_valid;
	logic              snap_ready;
	snap_t             snap;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= '0;
			size_m1_q <= '1;
		end else if (cfg_ch.valid) begin
			size_q    <= cfg_ch.resource_size;
			size_m1_q <= cfg_ch.resource_size - DATA_W'(1);
		end
	end

	hbrp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	hbrp_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.size       (size_q),
		.size_m1    (size_m1_q),
		.res_ch     (res_ch)
	);

endmodule

/* rtl/core/hbrp_parser.sv */
// ----------------------------------------------------------------------------
// hbrp_parser
// Input register and per-byte grammar state: prefix match, decimal
// accumulation with overflow detection, and a snapshot word at end of header.
// ----------------------------------------------------------------------------
module hbrp_parser import hbrp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	hbrp_in_if.sink in_ch,
	output logic  snap_valid,
	input  logic  snap_ready,
	output snap_t snap
);

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_START,
		PH_FIRST,
		PH_AFTER_DASH
	} phase_t;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eoh_s1;

	phase_t             phase_q;
	logic [2:0]         pos_q;
	logic [VALUE_W-1:0] first_q;
	logic [VALUE_W-1:0] last_q;
	logic               suffix_q;
	logic               lp_q;
	logic               digits_q;
	logic               inv_q;
	logic               ended_q;

	logic               valid_s2;
	snap_t              snap_s2;

	phase_t             n_phase;
	logic [2:0]         n_pos;
	logic [VALUE_W-1:0] n_first;
	logic [VALUE_W-1:0] n_last;
	logic               n_suffix;
	logic               n_lp;
	logic               n_digits;
	logic               n_inv;
	logic               n_ended;

	logic               is_digit;
	logic [3:0]         digit;
	logic [VALUE_W-1:0] acc_sel;
	logic [VALUE_W+3:0] acc_ext;
	logic [VALUE_W+3:0] acc_new;
	logic               acc_ovf;
	logic [VALUE_W-1:0] acc_val;
	logic               s1_take;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit    = byte_s1[3:0];
	assign acc_sel  = (phase_q == PH_AFTER_DASH && !suffix_q) ? last_q : first_q;
	assign acc_ext  = {4'b0000, acc_sel};
	assign acc_new  = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_W{1'b0}}, digit};
	assign acc_ovf  = |acc_new[VALUE_W+3:VALUE_W];
	assign acc_val  = acc_new[VALUE_W-1:0];

	always_comb begin
		n_phase  = phase_q;
		n_pos    = pos_q;
		n_first  = first_q;
		n_last   = last_q;
		n_suffix = suffix_q;
		n_lp     = lp_q;
		n_digits = digits_q;
		n_inv    = inv_q;
		n_ended  = ended_q;
		if (!ended_q && !inv_q) begin
			if (byte_s1 == 8'h00) begin
				n_ended = 1'b1;
			end else begin
				unique case (phase_q)
					PH_PREFIX: begin
						if (byte_s1 == prefix_char(pos_q)) begin
							n_pos = pos_q + 3'd1;
							if (pos_q == 3'(PREFIX_LEN - 1)) begin
								n_phase = PH_START;
							end
						end else begin
							n_inv = 1'b1;
						end
					end
					PH_START: begin
						if (byte_s1 == CH_DASH) begin
							n_suffix = 1'b1;
							n_digits = 1'b0;
							n_phase  = PH_AFTER_DASH;
						end else if (is_digit) begin
							n_phase = PH_FIRST;
							if (acc_ovf) begin
								n_inv = 1'b1;
							end else begin
								n_first = acc_val;
							end
						end else begin
							n_inv = 1'b1;
						end
					end
					PH_FIRST: begin
						if (is_digit) begin
							if (acc_ovf) begin
								n_inv = 1'b1;
							end else begin
								n_first = acc_val;
							end
						end else if (byte_s1 == CH_DASH) begin
							n_digits = 1'b0;
							n_phase  = PH_AFTER_DASH;
						end else begin
							n_inv = 1'b1;
						end
					end
					PH_AFTER_DASH: begin
						if (is_digit) begin
							n_digits = 1'b1;
							if (!suffix_q) begin
								n_lp = 1'b1;
							end
							if (acc_ovf) begin
								n_inv = 1'b1;
							end else if (suffix_q) begin
								n_first = acc_val;
							end else begin
								n_last = acc_val;
							end
						end else begin
							n_inv = 1'b1;
						end
					end
					default: begin
						n_inv = 1'b1;
					end
				endcase
			end
		end
	end

	assign s1_take     = valid_s1 && (!eoh_s1 || !valid_s2 || snap_ready);
	assign in_ch.ready = !valid_s1 || s1_take;
	assign snap_valid  = valid_s2;
	assign snap        = snap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			eoh_s1   <= 1'b0;
			phase_q  <= PH_PREFIX;
			pos_q    <= '0;
			first_q  <= '0;
			last_q   <= '0;
			suffix_q <= 1'b0;
			lp_q     <= 1'b0;
			digits_q <= 1'b0;
			inv_q    <= 1'b0;
			ended_q  <= 1'b0;
			valid_s2 <= 1'b0;
			snap_s2  <= '0;
		end else begin
			if (s1_take && eoh_s1) begin
				valid_s2 <= 1'b1;
			end else if (snap_valid && snap_ready) begin
				valid_s2 <= 1'b0;
			end
			if (s1_take) begin
				if (eoh_s1) begin
					snap_s2.bad          <= n_inv || (n_phase != PH_AFTER_DASH);
					snap_s2.suffix       <= n_suffix;
					snap_s2.digits       <= n_digits;
					snap_s2.last_present <= n_lp;
					snap_s2.first        <= n_first;
					snap_s2.last         <= n_last;
					phase_q              <= PH_PREFIX;
					pos_q                <= '0;
					first_q              <= '0;
					last_q               <= '0;
					suffix_q             <= 1'b0;
					lp_q                 <= 1'b0;
					digits_q             <= 1'b0;
					inv_q                <= 1'b0;
					ended_q              <= 1'b0;
				end else begin
					phase_q  <= n_phase;
					pos_q    <= n_pos;
					first_q  <= n_first;
					last_q   <= n_last;
					suffix_q <= n_suffix;
					lp_q     <= n_lp;
					digits_q <= n_digits;
					inv_q    <= n_inv;
					ended_q  <= n_ended;
				end
			end
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
				if (in_ch.valid) begin
					byte_s1 <= in_ch.header_byte;
					eoh_s1  <= in_ch.end_of_header;
				end
			end
		end
	end

endmodule

/* rtl/core/hbrp_check.sv */
// ----------------------------------------------------------------------------
// hbrp_check
// Range check against the resource size: status and clamp selection in one
// stage, the start or length subtraction into the result register.
// ----------------------------------------------------------------------------
module hbrp_check import hbrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              snap_valid,
	output logic              snap_ready,
	input  snap_t             snap,
	input  logic [DATA_W-1:0] size,
	input  logic [DATA_W-1:0] size_m1,
	hbrp_res_if.source        res_ch
);

	logic              valid_s3;
	status_t           status_s3;
	logic              suffix_s3;
	logic [DATA_W-1:0] sub_a_s3;
	logic [DATA_W-1:0] sub_b_s3;
	logic              cin_s3;
	logic [DATA_W-1:0] keep_s3;

	logic              valid_s4;
	status_t           status_s4;
	logic [DATA_W-1:0] start_s4;
	logic [DATA_W-1:0] len_s4;

	logic              free_s4;
	logic              free_s3;
	logic [DATA_W-1:0] first_w;
	logic [DATA_W-1:0] last_w;
	status_t           a_status;
	logic [DATA_W-1:0] a_sub_a;
	logic [DATA_W-1:0] a_sub_b;
	logic              a_cin;
	logic [DATA_W-1:0] a_keep;
	logic [DATA_W-1:0] diff;

	assign free_s4    = !valid_s4 || res_ch.ready;
	assign free_s3    = !valid_s3 || free_s4;
	assign snap_ready = free_s3;
	assign first_w    = DATA_W'(snap.first);
	assign last_w     = DATA_W'(snap.last);

	always_comb begin
		a_status = ST_INVALID;
		a_sub_a  = '0;
		a_sub_b  = '0;
		a_cin    = 1'b0;
		a_keep   = '0;
		if (snap.bad) begin
			a_status = ST_INVALID;
		end else if (snap.suffix) begin
			if (!snap.digits || first_w == '0) begin
				a_status = ST_INVALID;
			end else if (size == '0) begin
				a_status = ST_UNSAT;
			end else begin
				a_status = ST_OK;
				a_sub_a  = size;
				a_sub_b  = (first_w > size) ? size : first_w;
				a_keep   = (first_w > size) ? size : first_w;
			end
		end else if (first_w >= size) begin
			a_status = ST_UNSAT;
		end else if (snap.last_present && last_w < first_w) begin
			a_status = ST_INVALID;
		end else begin
			a_status = ST_OK;
			a_sub_a  = (snap.last_present && last_w < size_m1) ? last_w : size_m1;
			a_sub_b  = first_w;
			a_cin    = 1'b1;
			a_keep   = first_w;
		end
	end

	assign diff = sub_a_s3 - sub_b_s3 + DATA_W'(cin_s3);

	assign res_ch.valid        = valid_s4;
	assign res_ch.status       = status_s4;
	assign res_ch.range_start  = start_s4;
	assign res_ch.range_length = len_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			status_s3 <= ST_INVALID;
			suffix_s3 <= 1'b0;
			sub_a_s3  <= '0;
			sub_b_s3  <= '0;
			cin_s3    <= 1'b0;
			keep_s3   <= '0;
			valid_s4  <= 1'b0;
			status_s4 <= ST_INVALID;
			start_s4  <= '0;
			len_s4    <= '0;
		end else begin
			if (free_s3) begin
				valid_s3 <= snap_valid;
				if (snap_valid) begin
					status_s3 <= a_status;
					suffix_s3 <= snap.suffix;
					sub_a_s3  <= a_sub_a;
					sub_b_s3  <= a_sub_b;
					cin_s3    <= a_cin;
					keep_s3   <= a_keep;
				end
			end
			if (free_s4) begin
				valid_s4 <= valid_s3;
				if (valid_s3) begin
					status_s4 <= status_s3;
					if (status_s3 != ST_OK) begin
						start_s4 <= '0;
						len_s4   <= '0;
					end else if (suffix_s3) begin
						start_s4 <= diff;
						len_s4   <= keep_s3;
					end else begin
						start_s4 <= keep_s3;
						len_s4   <= diff;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && status_s4 == ST_OK) |-> (len_s4 != '0))
		else $error("ok result with zero length");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && status_s4 != ST_OK) |-> (start_s4 == '0 && len_s4 == '0))
		else $error("failed result carries nonzero range");

	a_within_size: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && status_s4 == ST_OK) |->
		(({1'b0, start_s4} + {1'b0, len_s4}) <= {1'b0, size}))
		else $error("ok range extends past resource size");

	a_stage_feed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && free_s4) |=> valid_s4)
		else $error("check stage word lost");
`endif

endmodule
